@@ design/ray_triangle_intersect_unit_macros.svh @@
// ----------------------------------------------------------------------------
// Ray/triangle intersection unit: assertion macros
// Shorthand for the concurrent checks on the unit's ports.
// ----------------------------------------------------------------------------
`ifndef RAY_TRIANGLE_INTERSECT_UNIT_MACROS_SVH
`define RAY_TRIANGLE_INTERSECT_UNIT_MACROS_SVH

// Checked only while reset is released.
`define RTI_ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define RTI_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ design/rti_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ray/triangle intersection package
// Types, constants and single precision arithmetic shared by the unit.
// ----------------------------------------------------------------------------
package rti_pkg;

  localparam int CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_DIST = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PAR_EPS  = 8'd1;

  localparam logic [31:0] RESET_MIN_DIST = 32'h3A83126F;
  localparam logic [31:0] RESET_PAR_EPS  = 32'h3727C5AC;
  localparam logic [31:0] CANON_NAN      = 32'h7FC00000;
  localparam logic [31:0] FP_ONE         = 32'h3F800000;
  localparam logic [31:0] FP_ZERO        = 32'h00000000;
  localparam logic [31:0] SIGN_MASK      = 32'h80000000;

  localparam int QUO_BITS      = 28;
  localparam int DIV_BITS_STEP = 2;
  localparam int DIV_STAGES    = QUO_BITS / DIV_BITS_STEP;

  typedef logic [2:0][31:0] vec3_t;

  typedef struct packed {
    logic [24:0]        rem;
    logic [23:0]        dvs;
    logic [QUO_BITS-1:0] quo;
    logic signed [9:0]  ea_eff;
    logic               sign;
    logic               nan;
    logic               inf_in;
    logic               zero_in;
  } div_t;

  typedef struct packed {
    logic        par_miss;
    logic [31:0] shd;
    logic [31:0] dq;
    logic [31:0] eq;
    logic [31:0] lim;
  } side_t;

  function automatic logic is_nan(logic [31:0] x);
    return (x[30:23] == 8'hFF) && (x[22:0] != 23'd0);
  endfunction

  function automatic logic is_inf(logic [31:0] x);
    return (x[30:23] == 8'hFF) && (x[22:0] == 23'd0);
  endfunction

  function automatic logic [5:0] lzc48(logic [47:0] m);
    logic [5:0] n;
    n = 6'd0;
    for (int i = 0; i < 48; i++) begin
      if (m[i]) begin
        n = 6'(47 - i);
      end
    end
    return n;
  endfunction

  // Rounds a normalized significand (bit 47 set) with biased exponent e.
  function automatic logic [31:0] fp_pack(logic sign, logic signed [10:0] e, logic [47:0] m);
    logic [23:0] mant;
    logic        g;
    logic        st;
    logic        inc;
    logic [72:0] ext;
    logic [10:0] sh;
    logic [8:0]  ef;
    logic [31:0] r;
    logic [31:0] res;
    if (e >= 11'sd255) begin
      res = {sign, 8'hFF, 23'd0};
    end else begin
      if (e >= 11'sd1) begin
        mant = m[47:24];
        g    = m[23];
        st   = |m[22:0];
        ef   = e[8:0];
      end else begin
        sh   = 11'(11'sd1 - e);
        if (sh > 11'd25) begin
          sh = 11'd25;
        end
        ext  = {m, 25'd0} >> sh;
        mant = ext[72:49];
        g    = ext[48];
        st   = |ext[47:0];
        ef   = 9'd0;
      end
      inc = g & (st | mant[0]);
      r   = {ef, mant[22:0]} + {31'd0, inc};
      if (r[31:23] >= 9'd255) begin
        res = {sign, 8'hFF, 23'd0};
      end else begin
        res = {sign, r[30:0]};
      end
    end
    return res;
  endfunction

  function automatic logic [31:0] fp_mul(logic [31:0] a, logic [31:0] b);
    logic              s;
    logic [7:0]        ea;
    logic [7:0]        eb;
    logic [23:0]       ma;
    logic [23:0]       mb;
    logic [47:0]       p;
    logic [5:0]        lz;
    logic signed [10:0] e;
    logic [31:0]       res;
    s  = a[31] ^ b[31];
    ea = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
    eb = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
    ma = {a[30:23] != 8'd0, a[22:0]};
    mb = {b[30:23] != 8'd0, b[22:0]};
    p  = ma * mb;
    lz = lzc48(p);
    e  = $signed({3'b000, ea}) + $signed({3'b000, eb}) - 11'sd126 - $signed({5'd0, lz});
    if (is_nan(a) || is_nan(b) || (is_inf(a) && (b[30:0] == 31'd0)) ||
        (is_inf(b) && (a[30:0] == 31'd0))) begin
      res = CANON_NAN;
    end else if (is_inf(a) || is_inf(b)) begin
      res = {s, 8'hFF, 23'd0};
    end else if ((a[30:0] == 31'd0) || (b[30:0] == 31'd0)) begin
      res = {s, 31'd0};
    end else begin
      res = fp_pack(s, e, 48'(p << lz));
    end
    return res;
  endfunction

  function automatic logic [31:0] fp_add(logic [31:0] a, logic [31:0] b);
    logic [31:0]       big;
    logic [31:0]       sml;
    logic [7:0]        el;
    logic [7:0]        es;
    logic [26:0]       ml;
    logic [26:0]       ms;
    logic [26:0]       al;
    logic [53:0]       ext;
    logic [7:0]        d;
    logic [27:0]       sum;
    logic [47:0]       s48;
    logic [5:0]        lz;
    logic signed [10:0] e;
    logic              sub;
    logic [31:0]       res;
    if (a[30:0] >= b[30:0]) begin
      big = a;
      sml = b;
    end else begin
      big = b;
      sml = a;
    end
    el  = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
    es  = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
    ml  = {big[30:23] != 8'd0, big[22:0], 3'b000};
    ms  = {sml[30:23] != 8'd0, sml[22:0], 3'b000};
    d   = el - es;
    ext = {ms, 27'd0} >> ((d > 8'd27) ? 8'd27 : d);
    al  = ext[53:27] | {26'd0, |ext[26:0]};
    sub = a[31] ^ b[31];
    sum = sub ? ({1'b0, ml} - {1'b0, al}) : ({1'b0, ml} + {1'b0, al});
    s48 = {sum, 20'd0};
    lz  = lzc48(s48);
    e   = $signed({3'b000, el}) + 11'sd1 - $signed({5'd0, lz});
    if (is_nan(a) || is_nan(b) || (is_inf(a) && is_inf(b) && sub)) begin
      res = CANON_NAN;
    end else if (is_inf(a)) begin
      res = a;
    end else if (is_inf(b)) begin
      res = b;
    end else if ((a[30:0] == 31'd0) && (b[30:0] == 31'd0)) begin
      res = {a[31] & b[31], 31'd0};
    end else if (a[30:0] == 31'd0) begin
      res = b;
    end else if (b[30:0] == 31'd0) begin
      res = a;
    end else if (sum == 28'd0) begin
      res = FP_ZERO;
    end else begin
      res = fp_pack(big[31], e, 48'(s48 << lz));
    end
    return res;
  endfunction

  function automatic logic [31:0] fp_sub(logic [31:0] a, logic [31:0] b);
    return fp_add(a, b ^ SIGN_MASK);
  endfunction

  function automatic logic fp_lt(logic [31:0] a, logic [31:0] b);
    logic [31:0] ka;
    logic [31:0] kb;
    ka = a[31] ? ~a : {1'b1, a[30:0]};
    kb = b[31] ? ~b : {1'b1, b[30:0]};
    if (is_nan(a) || is_nan(b) || ((a[30:0] == 31'd0) && (b[30:0] == 31'd0))) begin
      return 1'b0;
    end
    return ka < kb;
  endfunction

  function automatic logic fp_le(logic [31:0] a, logic [31:0] b);
    return !is_nan(a) && !is_nan(b) && !fp_lt(b, a);
  endfunction

  // Sets up 1/a as a long division of 2^50 by the normalized significand.
  function automatic div_t div_prep(logic [31:0] a);
    div_t        d;
    logic [23:0] m24;
    logic [5:0]  lz;
    logic [7:0]  ee;
    m24       = {a[30:23] != 8'd0, a[22:0]};
    lz        = lzc48({m24, 24'd0});
    ee        = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
    d.rem     = 25'h0800000;
    d.dvs     = 24'(m24 << lz);
    d.quo     = '0;
    d.ea_eff  = $signed({2'b00, ee}) - $signed({4'd0, lz});
    d.sign    = a[31];
    d.nan     = is_nan(a);
    d.inf_in  = is_inf(a);
    d.zero_in = (a[30:0] == 31'd0);
    return d;
  endfunction

  function automatic div_t div_step(div_t din);
    div_t d;
    logic q;
    d = din;
    for (int k = 0; k < DIV_BITS_STEP; k++) begin
      q = (d.rem >= {1'b0, d.dvs});
      if (q) begin
        d.rem = d.rem - {1'b0, d.dvs};
      end
      d.quo = {d.quo[QUO_BITS-2:0], q};
      d.rem = {d.rem[23:0], 1'b0};
    end
    return d;
  endfunction

  function automatic logic [31:0] div_finish(div_t d);
    logic [QUO_BITS:0]  qx;
    logic [47:0]        s48;
    logic [5:0]         lz;
    logic signed [10:0] e;
    logic [31:0]        res;
    qx  = {d.quo, d.rem != 25'd0};
    s48 = {qx, 19'd0};
    lz  = lzc48(s48);
    e   = 11'sd254 - 11'(d.ea_eff) - $signed({5'd0, lz});
    if (d.nan) begin
      res = CANON_NAN;
    end else if (d.inf_in) begin
      res = {d.sign, 31'd0};
    end else if (d.zero_in) begin
      res = {d.sign, 8'hFF, 23'd0};
    end else begin
      res = fp_pack(d.sign, e, 48'(s48 << lz));
    end
    return res;
  endfunction

endpackage

@@ design/ray_triangle_intersect_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ray/triangle intersection unit
// Pipelined single precision Moller-Trumbore test with one result per ray.
// ----------------------------------------------------------------------------
// Usage: a ray, a triangle (v0, edge1, edge2) and a distance limit arrive as
// one beat on the in_ channel, packed two IEEE singles per 64-bit port. Each
// input beat yields exactly one beat on the out_ channel carrying out_hit and
// out_hit_distance, which is zero on a miss.
// Throughput is one beat per cycle while in_ready is high: every stage holds
// one ray, and the reciprocal of the determinant is a restoring divider of
// 14 stages at two quotient bits each.
// The cfg_ channel writes the minimum distance (index 0) and the parallel
// epsilon (index 1); cfg_ready is always high, other indexes are dropped.
// Write configuration only while no beat is in flight.
// Reset clears all valid bits and loads the default configuration.
// When the receiver stalls, a two-entry output buffer absorbs the beat in
// flight; the pipeline freezes once that buffer fills and in_ready drops.
// ----------------------------------------------------------------------------
module ray_triangle_intersect_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [63:0]                   in_origin_xy,
  input  logic [63:0]                   in_origin_z_dir_x,
  input  logic [63:0]                   in_dir_yz,
  input  logic [63:0]                   in_vert_xy,
  input  logic [63:0]                   in_vert_z_edge1_x,
  input  logic [63:0]                   in_edge1_yz,
  input  logic [63:0]                   in_edge2_xy,
  input  logic [63:0]                   in_edge2_z_limit,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_hit,
  output logic [31:0]                   out_hit_distance,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [rti_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                   cfg_data
);

  logic en;

  logic [31:0] min_dist_r;
  logic [31:0] par_eps_r;

  rti_pkg::vec3_t org, dir, vtx, e1, e2;

  logic           p1_vld_r;
  rti_pkg::vec3_t p1_hpp_r, p1_hpn_r, p1_s_r, p1_dir_r, p1_e1_r, p1_e2_r;
  logic [31:0]    p1_lim_r;

  logic           p2_vld_r;
  rti_pkg::vec3_t p2_h_r, p2_s_r, p2_dir_r, p2_e1_r, p2_e2_r;
  logic [31:0]    p2_lim_r;

  logic           p3_vld_r;
  rti_pkg::vec3_t p3_ah_r, p3_sh_r, p3_qpp_r, p3_qpn_r, p3_dir_r, p3_e2_r;
  logic [31:0]    p3_lim_r;

  logic           p4_vld_r;
  logic [31:0]    p4_a01_r, p4_ah2_r, p4_sh01_r, p4_sh2_r, p4_lim_r;
  rti_pkg::vec3_t p4_q_r, p4_dir_r, p4_e2_r;

  logic           p5_vld_r;
  logic [31:0]    p5_a_r, p5_shd_r, p5_lim_r;
  rti_pkg::vec3_t p5_dqp_r, p5_eqp_r;

  logic           p6_vld_r;
  logic           p6_par_r;
  logic [31:0]    p6_a_r, p6_shd_r, p6_dq01_r, p6_dqp2_r, p6_eq01_r, p6_eqp2_r, p6_lim_r;

  logic           p7_vld_r;
  rti_pkg::div_t  p7_div_r;
  rti_pkg::side_t p7_side_r;

  logic [rti_pkg::DIV_STAGES-1:0] dvld_r;
  rti_pkg::div_t  dv_r [rti_pkg::DIV_STAGES];
  rti_pkg::side_t ds_r [rti_pkg::DIV_STAGES];

  logic           f0_vld_r;
  logic [31:0]    f0_f_r;
  rti_pkg::side_t f0_side_r;

  logic           r1_vld_r;
  logic           r1_par_r;
  logic [31:0]    r1_u_r, r1_v_r, r1_t_r, r1_lim_r;

  logic           r2_vld_r;
  logic           r2_miss_r;
  logic [31:0]    r2_uv_r, r2_t_r;

  logic           fin_vld_r;
  logic           fin_hit_r;
  logic [31:0]    fin_dist_r;

  logic           out_valid_r, skid_valid_r;
  logic           out_hit_r, skid_hit_r;
  logic [31:0]    out_dist_r, skid_dist_r;

  logic           fin_miss;

  assign en        = !skid_valid_r;
  assign in_ready  = en;
  assign cfg_ready = 1'b1;

  assign org = {in_origin_z_dir_x[63:32], in_origin_xy[31:0], in_origin_xy[63:32]};
  assign dir = {in_dir_yz[31:0], in_dir_yz[63:32], in_origin_z_dir_x[31:0]};
  assign vtx = {in_vert_z_edge1_x[63:32], in_vert_xy[31:0], in_vert_xy[63:32]};
  assign e1  = {in_edge1_yz[31:0], in_edge1_yz[63:32], in_vert_z_edge1_x[31:0]};
  assign e2  = {in_edge2_z_limit[63:32], in_edge2_xy[31:0], in_edge2_xy[63:32]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_dist_r <= rti_pkg::RESET_MIN_DIST;
      par_eps_r  <= rti_pkg::RESET_PAR_EPS;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        rti_pkg::CFG_MIN_DIST: min_dist_r <= cfg_data;
        rti_pkg::CFG_PAR_EPS:  par_eps_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_vld_r  <= 1'b0;
      p2_vld_r  <= 1'b0;
      p3_vld_r  <= 1'b0;
      p4_vld_r  <= 1'b0;
      p5_vld_r  <= 1'b0;
      p6_vld_r  <= 1'b0;
      p7_vld_r  <= 1'b0;
      dvld_r    <= '0;
      f0_vld_r  <= 1'b0;
      r1_vld_r  <= 1'b0;
      r2_vld_r  <= 1'b0;
      fin_vld_r <= 1'b0;
    end else if (en) begin
      p1_vld_r  <= in_valid;
      p2_vld_r  <= p1_vld_r;
      p3_vld_r  <= p2_vld_r;
      p4_vld_r  <= p3_vld_r;
      p5_vld_r  <= p4_vld_r;
      p6_vld_r  <= p5_vld_r;
      p7_vld_r  <= p6_vld_r;
      dvld_r    <= {dvld_r[rti_pkg::DIV_STAGES-2:0], p7_vld_r};
      f0_vld_r  <= dvld_r[rti_pkg::DIV_STAGES-1];
      r1_vld_r  <= f0_vld_r;
      r2_vld_r  <= r1_vld_r;
      fin_vld_r <= r2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_hpp_r[0] <= rti_pkg::fp_mul(dir[1], e2[2]);
      p1_hpn_r[0] <= rti_pkg::fp_mul(dir[2], e2[1]);
      p1_hpp_r[1] <= rti_pkg::fp_mul(dir[2], e2[0]);
      p1_hpn_r[1] <= rti_pkg::fp_mul(dir[0], e2[2]);
      p1_hpp_r[2] <= rti_pkg::fp_mul(dir[0], e2[1]);
      p1_hpn_r[2] <= rti_pkg::fp_mul(dir[1], e2[0]);
      for (int i = 0; i < 3; i++) begin
        p1_s_r[i] <= rti_pkg::fp_sub(org[i], vtx[i]);
      end
      p1_dir_r <= dir;
      p1_e1_r  <= e1;
      p1_e2_r  <= e2;
      p1_lim_r <= in_edge2_z_limit[31:0];

      for (int i = 0; i < 3; i++) begin
        p2_h_r[i] <= rti_pkg::fp_sub(p1_hpp_r[i], p1_hpn_r[i]);
      end
      p2_s_r   <= p1_s_r;
      p2_dir_r <= p1_dir_r;
      p2_e1_r  <= p1_e1_r;
      p2_e2_r  <= p1_e2_r;
      p2_lim_r <= p1_lim_r;

      for (int i = 0; i < 3; i++) begin
        p3_ah_r[i] <= rti_pkg::fp_mul(p2_e1_r[i], p2_h_r[i]);
        p3_sh_r[i] <= rti_pkg::fp_mul(p2_s_r[i], p2_h_r[i]);
      end
      p3_qpp_r[0] <= rti_pkg::fp_mul(p2_s_r[1], p2_e1_r[2]);
      p3_qpn_r[0] <= rti_pkg::fp_mul(p2_s_r[2], p2_e1_r[1]);
      p3_qpp_r[1] <= rti_pkg::fp_mul(p2_s_r[2], p2_e1_r[0]);
      p3_qpn_r[1] <= rti_pkg::fp_mul(p2_s_r[0], p2_e1_r[2]);
      p3_qpp_r[2] <= rti_pkg::fp_mul(p2_s_r[0], p2_e1_r[1]);
      p3_qpn_r[2] <= rti_pkg::fp_mul(p2_s_r[1], p2_e1_r[0]);
      p3_dir_r <= p2_dir_r;
      p3_e2_r  <= p2_e2_r;
      p3_lim_r <= p2_lim_r;

      p4_a01_r  <= rti_pkg::fp_add(p3_ah_r[0], p3_ah_r[1]);
      p4_ah2_r  <= p3_ah_r[2];
      p4_sh01_r <= rti_pkg::fp_add(p3_sh_r[0], p3_sh_r[1]);
      p4_sh2_r  <= p3_sh_r[2];
      for (int i = 0; i < 3; i++) begin
        p4_q_r[i] <= rti_pkg::fp_sub(p3_qpp_r[i], p3_qpn_r[i]);
      end
      p4_dir_r <= p3_dir_r;
      p4_e2_r  <= p3_e2_r;
      p4_lim_r <= p3_lim_r;

      p5_a_r   <= rti_pkg::fp_add(p4_a01_r, p4_ah2_r);
      p5_shd_r <= rti_pkg::fp_add(p4_sh01_r, p4_sh2_r);
      for (int i = 0; i < 3; i++) begin
        p5_dqp_r[i] <= rti_pkg::fp_mul(p4_dir_r[i], p4_q_r[i]);
        p5_eqp_r[i] <= rti_pkg::fp_mul(p4_e2_r[i], p4_q_r[i]);
      end
      p5_lim_r <= p4_lim_r;

      p6_a_r    <= p5_a_r;
      p6_par_r  <= rti_pkg::fp_lt(par_eps_r ^ rti_pkg::SIGN_MASK, p5_a_r) &&
                   rti_pkg::fp_lt(p5_a_r, par_eps_r);
      p6_shd_r  <= p5_shd_r;
      p6_dq01_r <= rti_pkg::fp_add(p5_dqp_r[0], p5_dqp_r[1]);
      p6_dqp2_r <= p5_dqp_r[2];
      p6_eq01_r <= rti_pkg::fp_add(p5_eqp_r[0], p5_eqp_r[1]);
      p6_eqp2_r <= p5_eqp_r[2];
      p6_lim_r  <= p5_lim_r;

      p7_div_r           <= rti_pkg::div_prep(p6_a_r);
      p7_side_r.par_miss <= p6_par_r;
      p7_side_r.shd      <= p6_shd_r;
      p7_side_r.dq       <= rti_pkg::fp_add(p6_dq01_r, p6_dqp2_r);
      p7_side_r.eq       <= rti_pkg::fp_add(p6_eq01_r, p6_eqp2_r);
      p7_side_r.lim      <= p6_lim_r;

      dv_r[0] <= rti_pkg::div_step(p7_div_r);
      ds_r[0] <= p7_side_r;
      for (int i = 1; i < rti_pkg::DIV_STAGES; i++) begin
        dv_r[i] <= rti_pkg::div_step(dv_r[i-1]);
        ds_r[i] <= ds_r[i-1];
      end

      f0_f_r    <= rti_pkg::div_finish(dv_r[rti_pkg::DIV_STAGES-1]);
      f0_side_r <= ds_r[rti_pkg::DIV_STAGES-1];

      r1_u_r   <= rti_pkg::fp_mul(f0_f_r, f0_side_r.shd);
      r1_v_r   <= rti_pkg::fp_mul(f0_f_r, f0_side_r.dq);
      r1_t_r   <= rti_pkg::fp_mul(f0_f_r, f0_side_r.eq);
      r1_par_r <= f0_side_r.par_miss;
      r1_lim_r <= f0_side_r.lim;

      r2_uv_r   <= rti_pkg::fp_add(r1_u_r, r1_v_r);
      r2_t_r    <= r1_t_r;
      r2_miss_r <= r1_par_r ||
                   rti_pkg::fp_lt(r1_u_r, rti_pkg::FP_ZERO) ||
                   rti_pkg::fp_lt(rti_pkg::FP_ONE, r1_u_r) ||
                   rti_pkg::fp_lt(r1_v_r, rti_pkg::FP_ZERO) ||
                   rti_pkg::fp_le(r1_t_r, min_dist_r) ||
                   rti_pkg::fp_le(r1_lim_r, r1_t_r);

      fin_hit_r  <= !fin_miss;
      fin_dist_r <= fin_miss ? rti_pkg::FP_ZERO :
                    (rti_pkg::is_nan(r2_t_r) ? rti_pkg::CANON_NAN : r2_t_r);
    end
  end

  assign fin_miss = r2_miss_r || rti_pkg::fp_lt(rti_pkg::FP_ONE, r2_uv_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || out_ready) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= fin_vld_r && en;
      end
    end else if (fin_vld_r && en) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_ready) begin
      if (skid_valid_r) begin
        out_hit_r  <= skid_hit_r;
        out_dist_r <= skid_dist_r;
      end else begin
        out_hit_r  <= fin_hit_r;
        out_dist_r <= fin_dist_r;
      end
    end else if (fin_vld_r && en) begin
      skid_hit_r  <= fin_hit_r;
      skid_dist_r <= fin_dist_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_hit          = out_hit_r;
  assign out_hit_distance = out_dist_r;

endmodule

@@ design/rti_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ray/triangle intersection checker
// Port level checks on the intersection unit, bound to its top level.
// ----------------------------------------------------------------------------
`include "ray_triangle_intersect_unit_macros.svh"

module rti_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic [63:0]                   in_origin_xy,
  input logic [63:0]                   in_origin_z_dir_x,
  input logic [63:0]                   in_dir_yz,
  input logic [63:0]                   in_vert_xy,
  input logic [63:0]                   in_vert_z_edge1_x,
  input logic [63:0]                   in_edge1_yz,
  input logic [63:0]                   in_edge2_xy,
  input logic [63:0]                   in_edge2_z_limit,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic                          out_hit,
  input logic [31:0]                   out_hit_distance,
  input logic                          cfg_valid,
  input logic                          cfg_ready,
  input logic [rti_pkg::CFG_IDX_W-1:0] cfg_index,
  input logic [31:0]                   cfg_data
);

  `RTI_ASSERT_CLK(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_hit) && $stable(out_hit_distance), "stalled result beat changed")
  `RTI_ASSERT_CLK(a_miss_zero, out_valid && !out_hit |-> out_hit_distance == rti_pkg::FP_ZERO, "miss beat carries a nonzero distance")
  `RTI_ASSERT_CLK(a_nan_canon, out_valid && out_hit && out_hit_distance[30:23] == 8'hFF |-> out_hit_distance[22:0] == 23'd0 || out_hit_distance == rti_pkg::CANON_NAN, "hit distance NaN is not canonical")
  `RTI_ASSERT_RST(a_reset_empty, !rst_n |=> !out_valid, "result beat shown right after reset")

endmodule

bind ray_triangle_intersect_unit rti_checker u_rti_checker (.*);
